// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/lcd_seq_pkg.sv -----
// ---------------------------------------------------------------------------
// Character display sequencer package
// Request kinds, register indexes, pin-state type and fixed constants.
// ---------------------------------------------------------------------------
package lcd_seq_pkg;

   typedef enum logic [1:0] {
      KIND_INIT     = 2'd0,
      KIND_COMMAND  = 2'd1,
      KIND_DATA     = 2'd2,
      KIND_RESERVED = 2'd3
   } kind_type;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_PULSE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTE_WAIT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_POWER_UP   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_GAP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LATER_GAP  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CLEAR_WAIT = 3'd5;

   localparam logic [7:0]  RST_PULSE      = 8'd1;
   localparam logic [15:0] RST_BYTE_WAIT  = 16'd2;
   localparam logic [15:0] RST_POWER_UP   = 16'd2000;
   localparam logic [15:0] RST_FIRST_GAP  = 16'd200;
   localparam logic [15:0] RST_LATER_GAP  = 16'd8;
   localparam logic [15:0] RST_CLEAR_WAIT = 16'd80;

   // Init byte commands: display on / cursor off, then clear
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [3:0] NIB_WAKE       = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;

   localparam int unsigned STEP_W = 5;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd5;
   localparam logic [STEP_W-1:0] INIT_CMD0_STEP  = 5'd11;
   localparam logic [STEP_W-1:0] INIT_CMD1_STEP  = 5'd17;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd22;

   localparam int unsigned HOLD_W = 17;

   typedef struct packed {
      logic [3:0]        nibble;
      logic              reg_select;
      logic              enable;
      logic [HOLD_W-1:0] hold_units;
      logic              last;
   } pin_state_type;

endpackage

// ----- sv/char_lcd_nibble_sequencer.sv -----
// ---------------------------------------------------------------------------
// Character display nibble sequencer
// Turns init, command and data requests into timed pin states for a
// 4-bit character display bus.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per request. tuser carries the kind (init,
//            command, data; the spare code is taken and dropped), tdata the
//            byte. Init ignores the byte.
//   rsp_*  : one transaction per pin state: nibble, E level and hold time in
//            25 us units in tdata, RS in tuser, tlast on the final state.
//   csr_*  : register writes (index, data), always ready; write only while
//            the block is idle.
// Flow: a taken request is registered with the step counter, then its
//   first pin state enters the result register. Throughput: one pin state
//   per cycle unless rsp_tready stalls; a byte run has six states, an init
//   run 23, walked by the step counter. The next request is taken as its
//   predecessor's final state is produced, so runs follow with no gap.
// Reset: registers return to their documented defaults, any run in flight
//   is dropped and the result register is emptied.
// Stall: while rsp_tready is low the result register holds and the step
//   counter waits; the request side stays ready only if no run is active.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_nibble_sequencer
   import lcd_seq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] value
   input  logic [1:0]             req_tuser,   // [1:0] kind
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // [3:0] nibble, [4] enable,
                                               // [21:5] hold_units, [23:22] zero
   output logic                   rsp_tuser,   // [0] reg_select
   output logic                   rsp_tlast,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   // configuration registers
   logic [7:0]  pulse_ff;
   logic [15:0] byte_wait_ff;
   logic [15:0] power_up_ff;
   logic [15:0] first_gap_ff;
   logic [15:0] later_gap_ff;
   logic [15:0] clear_wait_ff;

   // request holding register and step counter
   logic              active_ff;
   kind_type          kind_ff;
   logic [7:0]        value_ff;
   logic [STEP_W-1:0] step_ff;

   // result register
   logic              rsp_valid_ff;
   pin_state_type     rsp_ff;

   pin_state_type     pin_in;
   logic              advance;
   logic              step_last;
   logic              req_accept;
   kind_type          req_kind;

   // byte sub-sequence selection
   logic [2:0]        byte_step;
   logic [7:0]        byte_val;
   logic [HOLD_W-1:0] final_hold;
   logic [HOLD_W-1:0] pulse_hold;

   assign req_kind   = kind_type'(req_tuser);
   assign advance    = active_ff && (!rsp_valid_ff || rsp_tready);
   assign step_last  = (kind_ff == KIND_INIT) ? (step_ff == INIT_LAST_STEP)
                                              : (step_ff == BYTE_LAST_STEP);
   // take a new request when idle, or as the last state of a run goes out
   assign req_tready = !active_ff || (advance && step_last);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign pulse_hold = HOLD_W'(pulse_ff);

   // pin state for the current step
   always_comb begin
      pin_in     = '0;
      byte_step  = '0;
      byte_val   = value_ff;
      final_hold = HOLD_W'(byte_wait_ff);
      pin_in.last = step_last;
      if (kind_ff == KIND_INIT && step_ff < INIT_CMD0_STEP) begin
         // wake-up part of init: power-up wait, three nibble-3 pulses, nibble 2
         case (step_ff)
            5'd0: begin
               pin_in.hold_units = HOLD_W'(power_up_ff);
            end
            5'd1: begin
               pin_in.nibble = NIB_WAKE;
            end
            5'd2, 5'd4, 5'd6: begin
               pin_in.nibble     = NIB_WAKE;
               pin_in.enable     = 1'b1;
               pin_in.hold_units = pulse_hold;
            end
            5'd3: begin
               pin_in.nibble     = NIB_WAKE;
               pin_in.hold_units = HOLD_W'(first_gap_ff);
            end
            5'd5, 5'd7: begin
               pin_in.nibble     = NIB_WAKE;
               pin_in.hold_units = HOLD_W'(later_gap_ff);
            end
            5'd9: begin
               pin_in.nibble     = NIB_FOUR_BIT;
               pin_in.enable     = 1'b1;
               pin_in.hold_units = pulse_hold;
            end
            default: begin
               pin_in.nibble = NIB_FOUR_BIT;
            end
         endcase
      end else begin
         if (kind_ff == KIND_INIT) begin
            if (step_ff < INIT_CMD1_STEP) begin
               byte_step = 3'(step_ff - INIT_CMD0_STEP);
               byte_val  = CMD_DISPLAY_ON;
            end else begin
               byte_step  = 3'(step_ff - INIT_CMD1_STEP);
               byte_val   = CMD_CLEAR;
               final_hold = HOLD_W'(byte_wait_ff) + HOLD_W'(clear_wait_ff);
            end
         end else begin
            byte_step         = step_ff[2:0];
            pin_in.reg_select = (kind_ff == KIND_DATA);
         end
         pin_in.nibble = (byte_step < 3'd3) ? byte_val[7:4] : byte_val[3:0];
         case (byte_step)
            3'd1, 3'd4: begin
               pin_in.enable     = 1'b1;
               pin_in.hold_units = pulse_hold;
            end
            3'd5: begin
               pin_in.hold_units = final_hold;
            end
            default: begin
               pin_in.hold_units = '0;
            end
         endcase
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pulse_ff      <= RST_PULSE;
         byte_wait_ff  <= RST_BYTE_WAIT;
         power_up_ff   <= RST_POWER_UP;
         first_gap_ff  <= RST_FIRST_GAP;
         later_gap_ff  <= RST_LATER_GAP;
         clear_wait_ff <= RST_CLEAR_WAIT;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_PULSE:      pulse_ff      <= csr_data[7:0];
               REG_BYTE_WAIT:  byte_wait_ff  <= csr_data;
               REG_POWER_UP:   power_up_ff   <= csr_data;
               REG_FIRST_GAP:  first_gap_ff  <= csr_data;
               REG_LATER_GAP:  later_gap_ff  <= csr_data;
               REG_CLEAR_WAIT: clear_wait_ff <= csr_data;
               default: begin
               end
            endcase
         end

         if (advance) begin
            rsp_valid_ff <= 1'b1;
            step_ff      <= step_ff + 1'b1;
            if (step_last) begin
               active_ff <= 1'b0;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // a new request overrides the finishing run's counter update
         if (req_accept) begin
            step_ff   <= '0;
            active_ff <= (req_kind != KIND_RESERVED);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_kind;
         value_ff <= req_tdata;
      end
      if (advance) begin
         rsp_ff <= pin_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.hold_units, rsp_ff.enable, rsp_ff.nibble};
   assign rsp_tuser  = rsp_ff.reg_select;
   assign rsp_tlast  = rsp_ff.last;

   // byte runs never step past their sixth state
   `ASSERT_IMPL(a_byte_step_range, clock, reset,
      active_ff && kind_ff != KIND_INIT, step_ff <= BYTE_LAST_STEP)
   // a request taken mid-run only ever coincides with the run's final state
   `ASSERT_IMPL(a_overlap_at_end, clock, reset,
      req_accept && active_ff, advance && step_last)
   // the spare kind starts no run
   `ASSERT_NEXT(a_reserved_dropped, clock, reset,
      req_accept && req_kind == KIND_RESERVED, !active_ff)
   // a stalled result freezes the step counter
   `ASSERT_NEXT(a_stall_freezes_step, clock, reset,
      rsp_valid_ff && !rsp_tready && !req_accept, $stable(step_ff))

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Character display sequencer testbench
// Drives init, command and data requests with random gaps, and applies
// random back-pressure on the pin-state stream. A behavioural model computes
// the pin states that each request should produce, including the holds taken
// from the timing registers. The registers are rewritten between phases,
// with all-zero and all-ones settings among them. Every pin state is checked
// field by field, in order.
// ---------------------------------------------------------------------------
module tb;
   import lcd_seq_pkg::*;

   // Index codes that map to no register
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

   localparam int RANDOM_ITEMS = 190;
   localparam int DIR_ROWS     = 21;

   // One directed request. Where typed_ok is set, the final pin state is
   // typed in by hand and replaces the predicted one.
   typedef struct packed {
      logic [1:0]    group;
      kind_type      kind;
      logic [7:0]    value;
      logic          typed_ok;
      pin_state_type typed_final;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [7:0] value
   logic [1:0]  req_tuser = '0;      // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [3:0] nibble, [4] enable, [21:5] hold, [23:22] zero
   logic        rsp_tuser;           // [0] reg_select
   logic        rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_data = '0;

   // Timing register copies, tracked from accepted csr transactions
   logic [7:0]  cfg_pulse;
   logic [15:0] cfg_byte_wait;
   logic [15:0] cfg_power_up;
   logic [15:0] cfg_first_gap;
   logic [15:0] cfg_later_gap;
   logic [15:0] cfg_clear_wait;

   pin_state_type pending_pins [$];   // pin states still owed by the block
   pin_state_type want_pin;
   logic          row_typed_ok = 1'b0;
   pin_state_type row_typed = '0;

   int fault_count = 0;
   int rsp_hold_cycles = 0;           // long hold-off request for the receiver
   bit idle_sender = 1'b0;
   bit idle_receiver = 1'b0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      // reset timing: pulse 1, byte wait 2, clear wait 80
      '{2'd0, KIND_INIT,     8'hA5, 1'b1, {4'h1, 1'b0, 1'b0, 17'd82, 1'b1}},
      '{2'd0, KIND_COMMAND,  8'h00, 1'b1, {4'h0, 1'b0, 1'b0, 17'd2,  1'b1}},
      '{2'd0, KIND_COMMAND,  8'hFF, 1'b1, {4'hF, 1'b0, 1'b0, 17'd2,  1'b1}},
      '{2'd0, KIND_DATA,     8'h00, 1'b1, {4'h0, 1'b1, 1'b0, 17'd2,  1'b1}},
      '{2'd0, KIND_DATA,     8'hFF, 1'b1, {4'hF, 1'b1, 1'b0, 17'd2,  1'b1}},
      '{2'd0, KIND_RESERVED, 8'h5A, 1'b0, '0},
      '{2'd0, KIND_DATA,     8'h81, 1'b0, '0},
      '{2'd0, KIND_COMMAND,  8'h7E, 1'b0, '0},
      '{2'd0, KIND_INIT,     8'h00, 1'b1, {4'h1, 1'b0, 1'b0, 17'd82, 1'b1}},
      '{2'd0, KIND_RESERVED, 8'hFF, 1'b0, '0},
      '{2'd0, KIND_DATA,     8'h3C, 1'b0, '0},
      '{2'd0, KIND_INIT,     8'hFF, 1'b0, '0},
      // every register at its maximum: clear hold is 65535 + 65535
      '{2'd1, KIND_INIT,     8'h5A, 1'b1, {4'h1, 1'b0, 1'b0, 17'd131070, 1'b1}},
      '{2'd1, KIND_DATA,     8'hFF, 1'b1, {4'hF, 1'b1, 1'b0, 17'd65535,  1'b1}},
      '{2'd1, KIND_COMMAND,  8'h5A, 1'b0, '0},
      '{2'd1, KIND_RESERVED, 8'h00, 1'b0, '0},
      '{2'd1, KIND_DATA,     8'hC3, 1'b0, '0},
      // every register at zero
      '{2'd2, KIND_INIT,     8'h00, 1'b1, {4'h1, 1'b0, 1'b0, 17'd0, 1'b1}},
      '{2'd2, KIND_COMMAND,  8'h00, 1'b1, {4'h0, 1'b0, 1'b0, 17'd0, 1'b1}},
      '{2'd2, KIND_DATA,     8'hA5, 1'b0, '0},
      '{2'd2, KIND_COMMAND,  8'hF0, 1'b0, '0}
   };

   char_lcd_nibble_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block locks up
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Pin-state model
   // ------------------------------------------------------------------------
   function automatic void add_pin(input logic [3:0] nib, input logic rs, input logic en,
                                   input logic [HOLD_W-1:0] hold);
      pin_state_type pin;
      pin.nibble     = nib;
      pin.reg_select = rs;
      pin.enable     = en;
      pin.hold_units = hold;
      pin.last       = 1'b0;
      pending_pins.push_back(pin);
   endfunction

   // E low, E high for the pulse, E low for the given hold
   function automatic void add_strobe(input logic [3:0] nib, input logic rs,
                                      input logic [HOLD_W-1:0] after);
      add_pin(nib, rs, 1'b0, '0);
      add_pin(nib, rs, 1'b1, HOLD_W'(cfg_pulse));
      add_pin(nib, rs, 1'b0, after);
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic rs,
                                    input logic [HOLD_W-1:0] final_hold);
      add_strobe(b[7:4], rs, '0);
      add_strobe(b[3:0], rs, final_hold);
   endfunction

   function automatic void predict_pin_run(input kind_type kind, input logic [7:0] value,
                                           input logic typed_ok,
                                           input pin_state_type typed_final);
      pin_state_type tail;
      case (kind)
         KIND_INIT: begin
            add_pin(4'h0, 1'b0, 1'b0, HOLD_W'(cfg_power_up));
            add_pin(NIB_WAKE, 1'b0, 1'b0, '0);
            add_pin(NIB_WAKE, 1'b0, 1'b1, HOLD_W'(cfg_pulse));
            add_pin(NIB_WAKE, 1'b0, 1'b0, HOLD_W'(cfg_first_gap));
            add_pin(NIB_WAKE, 1'b0, 1'b1, HOLD_W'(cfg_pulse));
            add_pin(NIB_WAKE, 1'b0, 1'b0, HOLD_W'(cfg_later_gap));
            add_pin(NIB_WAKE, 1'b0, 1'b1, HOLD_W'(cfg_pulse));
            add_pin(NIB_WAKE, 1'b0, 1'b0, HOLD_W'(cfg_later_gap));
            add_strobe(NIB_FOUR_BIT, 1'b0, '0);
            add_byte(CMD_DISPLAY_ON, 1'b0, HOLD_W'(cfg_byte_wait));
            // clear needs the extra wait on top of the byte wait
            add_byte(CMD_CLEAR, 1'b0, HOLD_W'(cfg_byte_wait) + HOLD_W'(cfg_clear_wait));
         end
         KIND_COMMAND: add_byte(value, 1'b0, HOLD_W'(cfg_byte_wait));
         KIND_DATA:    add_byte(value, 1'b1, HOLD_W'(cfg_byte_wait));
         default:      return;   // spare kind: dropped silently
      endcase
      tail = pending_pins.pop_back();
      tail.last = 1'b1;
      if (typed_ok)
         tail = typed_final;
      pending_pins.push_back(tail);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: register copies, prediction on request transactions, checks on
   // result transactions. All sampled at the rising edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         cfg_pulse      <= RST_PULSE;
         cfg_byte_wait  <= RST_BYTE_WAIT;
         cfg_power_up   <= RST_POWER_UP;
         cfg_first_gap  <= RST_FIRST_GAP;
         cfg_later_gap  <= RST_LATER_GAP;
         cfg_clear_wait <= RST_CLEAR_WAIT;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PULSE:      cfg_pulse      <= csr_data[7:0];
               REG_BYTE_WAIT:  cfg_byte_wait  <= csr_data;
               REG_POWER_UP:   cfg_power_up   <= csr_data;
               REG_FIRST_GAP:  cfg_first_gap  <= csr_data;
               REG_LATER_GAP:  cfg_later_gap  <= csr_data;
               REG_CLEAR_WAIT: cfg_clear_wait <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_pin_run(kind_type'(req_tuser), req_tdata, row_typed_ok, row_typed);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pins.size() == 0) begin
               $error("pin state with none expected: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fault_count++;
            end else begin
               want_pin = pending_pins.pop_front();
               check_field("nibble", want_pin.nibble, rsp_tdata[3:0]);
               check_field("enable", want_pin.enable, rsp_tdata[4]);
               check_field("hold_units", want_pin.hold_units, rsp_tdata[21:5]);
               check_field("pad", 0, rsp_tdata[23:22]);
               check_field("reg_select", want_pin.reg_select, rsp_tuser);
               check_field("last", want_pin.last, rsp_tlast);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random ready gaps per transaction, or one long hold-off on
   // request, counted here in cycles.
   // ------------------------------------------------------------------------
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            n = idle_receiver ? $urandom_range(0, 8) : 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus tasks; all entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic push_request(input kind_type kind, input logic [7:0] value,
                               input logic typed_ok, input pin_state_type typed_final);
      int gap;
      gap = idle_sender ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser    <= kind;
      req_tdata    <= value;
      row_typed_ok <= typed_ok;
      row_typed    <= typed_final;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic write_all_regs(input logic [7:0] pulse, input logic [15:0] byte_wait,
                                 input logic [15:0] power_up, input logic [15:0] first_gap,
                                 input logic [15:0] later_gap, input logic [15:0] clear_wait,
                                 input bit also_unused);
      // upper byte of the pulse write must be dropped by the block
      write_reg(REG_PULSE, {8'($urandom), pulse});
      write_reg(REG_BYTE_WAIT, byte_wait);
      write_reg(REG_POWER_UP, power_up);
      write_reg(REG_FIRST_GAP, first_gap);
      write_reg(REG_LATER_GAP, later_gap);
      write_reg(REG_CLEAR_WAIT, clear_wait);
      if (also_unused)
         write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Stop offering, let every owed pin state arrive, then idle on in case
   // a dropped spare-kind request is still being digested.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_pins.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int       counted;
      int       phase;
      int       burst;
      int       pick;
      int       guard;
      int       cfg_mode;
      kind_type kind;
      logic [1:0] cur_group;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed part, one register setting per group
      cur_group = 2'd0;
      idle_sender = 1'b1;
      idle_receiver = 1'b1;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].group != cur_group) begin
            settle();
            cur_group = dir_rows[i].group;
            if (cur_group == 2'd1)
               write_all_regs(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
            else
               write_all_regs(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
         end
         push_request(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed_ok,
                      dir_rows[i].typed_final);
      end

      // Random part in phases, each with its own timing setting
      counted = 0;
      phase = 0;
      while (counted < RANDOM_ITEMS) begin
         settle();
         idle_sender = ($urandom_range(0, 3) != 0);
         idle_receiver = ($urandom_range(0, 3) != 0);
         cfg_mode = $urandom_range(0, 5);
         case (cfg_mode)
            0: write_all_regs(8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              1'b1);
            1: write_all_regs(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              1'b0);
            2: write_all_regs(8'($urandom_range(0, 3)), 16'($urandom_range(0, 20)),
                              16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                              16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                              1'b1);
            default: write_all_regs(8'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom),
                                    1'($urandom_range(0, 1)));
         endcase
         // one phase starts with the receiver stalled for a long stretch while
         // the sender keeps offering, so the block backs up onto its input
         if (phase == 1) begin
            idle_sender = 1'b0;
            rsp_hold_cycles = 400;
         end
         burst = $urandom_range(25, 45);
         for (int j = 0; j < burst && counted < RANDOM_ITEMS; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)      kind = KIND_INIT;
            else if (pick < 50) kind = KIND_COMMAND;
            else if (pick < 92) kind = KIND_DATA;
            else                kind = KIND_RESERVED;
            push_request(kind, 8'($urandom), 1'b0, '0);
            if (kind != KIND_RESERVED)
               counted++;
         end
         phase++;
      end

      // Drain, bounded
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_pins.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (pending_pins.size() != 0) begin
         $error("%0d pin states never arrived", pending_pins.size());
         fault_count++;
      end

      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- char_lcd_nibble_sequencer.f -----
+incdir+sv
sv/lcd_seq_pkg.sv
sv/char_lcd_nibble_sequencer.sv
test/tb.sv
